@@ src/rmm_pkg.sv @@
// shared types and constants for the running min, max and mean block
package rmm_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned IN_W     = SAMPLE_W + TIME_W;
  localparam int unsigned OUT_W    = 3 * SAMPLE_W + 2 * TIME_W + COUNT_W;
  localparam int unsigned DIV_STEPS = SAMPLE_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic div_last;
  } status_t;

endpackage

@@ src/rmm_ctrl.sv @@
// controller: request handshakes and sequencing of the mean divider
module rmm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  input  rmm_pkg::status_t status_i,
  output rmm_pkg::cmd_t    cmd_o
);
  import rmm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = status_i.first ? ST_COMMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/rmm_dp.sv @@
// datapath: statistics registers, restoring divider and result register
module rmm_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [rmm_pkg::IN_W-1:0]  in_data_i,
  output logic [rmm_pkg::OUT_W-1:0] out_data_o,
  input  rmm_pkg::cmd_t             cmd_i,
  output rmm_pkg::status_t          status_o
);
  import rmm_pkg::*;

  // statistics
  logic [COUNT_W-1:0]         count_q, count_d;
  logic signed [SAMPLE_W-1:0] low_q, low_d;
  logic signed [SAMPLE_W-1:0] high_q, high_d;
  logic signed [SAMPLE_W-1:0] avg_q, avg_d;
  logic [TIME_W-1:0]          first_q, first_d;
  logic [TIME_W-1:0]          last_q, last_d;

  // latched request and divider
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [TIME_W-1:0]          tim_q;
  logic                       neg_q;
  logic [SAMPLE_W-1:0]        dvd_q, dvd_d;
  logic [COUNT_W:0]           rem_q, rem_d;
  logic [COUNT_W:0]           dvs_q;
  logic [STEP_W-1:0]          step_q, step_d;

  logic signed [SAMPLE_W-1:0] in_smp;
  logic [TIME_W-1:0]          in_tim;
  logic [SAMPLE_W:0]          diff;
  logic [SAMPLE_W:0]          diff_mag;
  logic [COUNT_W+1:0]         trial;
  logic [COUNT_W+1:0]         trial_sub;
  logic                       q_bit;
  logic [SAMPLE_W:0]          q_signed;
  logic [SAMPLE_W:0]          avg_sum;
  logic                       first;

  assign in_smp = in_data_i[SAMPLE_W-1:0];
  assign in_tim = in_data_i[IN_W-1:SAMPLE_W];
  assign first  = (count_q == '0);

  assign status_o.first    = first;
  assign status_o.div_last = (step_q == STEP_W'(DIV_STEPS - 1));

  // sample minus mean, exact in one extra bit
  assign diff     = {in_smp[SAMPLE_W-1], in_smp} - {avg_q[SAMPLE_W-1], avg_q};
  assign diff_mag = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

  assign trial     = {rem_q, dvd_q[SAMPLE_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign q_bit     = (trial >= {1'b0, dvs_q});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (cmd_i.load) begin
      dvd_d  = diff_mag[SAMPLE_W-1:0];
      rem_d  = '0;
      step_d = '0;
    end else if (cmd_i.step) begin
      dvd_d  = {dvd_q[SAMPLE_W-2:0], q_bit};
      rem_d  = q_bit ? trial_sub[COUNT_W:0] : trial[COUNT_W:0];
      step_d = step_q + 1'b1;
    end
  end

  assign q_signed = neg_q ? (~{1'b0, dvd_q} + 1'b1) : {1'b0, dvd_q};
  assign avg_sum  = {avg_q[SAMPLE_W-1], avg_q} + q_signed;

  always_comb begin
    count_d = count_q;
    low_d   = low_q;
    high_d  = high_q;
    avg_d   = avg_q;
    first_d = first_q;
    last_d  = last_q;
    if (cmd_i.commit) begin
      if (first) begin
        low_d   = smp_q;
        high_d  = smp_q;
        avg_d   = smp_q;
        first_d = tim_q;
        last_d  = tim_q;
      end else begin
        if (smp_q < low_q) begin
          low_d = smp_q;
        end
        if (smp_q > high_q) begin
          high_d = smp_q;
        end
        if (tim_q < first_q) begin
          first_d = tim_q;
        end
        if (tim_q > last_q) begin
          last_d = tim_q;
        end
        avg_d = avg_sum[SAMPLE_W-1:0];
      end
      // saturate at all ones
      if (count_q != '1) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      low_q   <= '0;
      high_q  <= '0;
      avg_q   <= '0;
      first_q <= '0;
      last_q  <= '0;
      step_q  <= '0;
    end else begin
      count_q <= count_d;
      low_q   <= low_d;
      high_q  <= high_d;
      avg_q   <= avg_d;
      first_q <= first_d;
      last_q  <= last_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      smp_q <= in_smp;
      tim_q <= in_tim;
      neg_q <= diff[SAMPLE_W];
      dvs_q <= {1'b0, count_q} + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_o <= {count_d, last_d, first_d, avg_d, high_d, low_d};
    end
  end

endmodule

@@ src/running_min_max_mean_top.sv @@
// top level of the running min, max and mean statistics block
//
// channel  dir  width  contents
// s_axis   in   96     sample, timestamp
// m_axis   out  256    min, max, mean, earliest, latest, points seen
//
// a first request is accepted and then written to the result register; every later one
// is accepted, passes the bit-serial restoring divider of the mean update and is then
// written to the result register. the next request is accepted while a result waits
// in the output register; the commit stalls until it is taken.
// reset clears all statistics to zero.
module running_min_max_mean_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // sample [31:0], timestamp [95:32]
  input  logic [rmm_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // min_sample [31:0], max_sample [63:32], mean_sample [95:64],
  // earliest_time [159:96], latest_time [223:160], points_seen [255:224]
  output logic [rmm_pkg::OUT_W-1:0] m_axis_tdata
);
  import rmm_pkg::*;

  cmd_t    cmd;
  status_t status;

  rmm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  rmm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

@@ verif/tb_running_min_max_mean_top.sv @@
// testbench for the running min, max and mean statistics block
module tb_running_min_max_mean_top;
  import rmm_pkg::*;

  localparam int unsigned RAND_ITEMS  = 700;
  localparam int unsigned QUIET_ITEMS = 100;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned TAIL_CYCLES = 40;

  // matches the m_axis tdata layout, first field in the top bits
  typedef struct packed {
    logic [COUNT_W-1:0]  points_seen;
    logic [TIME_W-1:0]   latest_time;
    logic [TIME_W-1:0]   earliest_time;
    logic [SAMPLE_W-1:0] mean_sample;
    logic [SAMPLE_W-1:0] max_sample;
    logic [SAMPLE_W-1:0] min_sample;
  } stats_t;

  class stats_tracker;
    int unsigned     points;
    int              lowest;
    int              highest;
    int              mean;
    longint unsigned first_ts;
    longint unsigned last_ts;
    stats_t          expected_stats[$];
    int unsigned     errors;
    int unsigned     checked;

    function new();
      points   = 0;
      lowest   = 0;
      highest  = 0;
      mean     = 0;
      first_ts = 0;
      last_ts  = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    // advance the statistics by one accepted request and queue the result
    function void note_sample(logic [SAMPLE_W-1:0] raw, logic [TIME_W-1:0] ts);
      int     s;
      longint diff;
      longint divisor;
      stats_t exp_s;
      s = int'(signed'(raw));
      if (points == 0) begin
        first_ts = ts;
        last_ts  = ts;
        lowest   = s;
        highest  = s;
        mean     = s;
      end else begin
        if (s < lowest) lowest = s;
        if (s > highest) highest = s;
        if (ts > last_ts) last_ts = ts;
        if (ts < first_ts) first_ts = ts;
        // exact difference over count + 1, truncated toward zero
        diff    = longint'(s) - longint'(mean);
        divisor = longint'(points) + 1;
        mean    = int'(longint'(mean) + diff / divisor);
      end
      if (points != 32'hFFFF_FFFF) points++;
      exp_s.min_sample    = lowest;
      exp_s.max_sample    = highest;
      exp_s.mean_sample   = mean;
      exp_s.earliest_time = first_ts;
      exp_s.latest_time   = last_ts;
      exp_s.points_seen   = points;
      expected_stats.push_back(exp_s);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_stats(logic [OUT_W-1:0] data);
      stats_t act_s;
      stats_t exp_s;
      act_s = data;
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      exp_s = expected_stats.pop_front();
      checked++;
      compare_field("min_sample", 64'(exp_s.min_sample), 64'(act_s.min_sample));
      compare_field("max_sample", 64'(exp_s.max_sample), 64'(act_s.max_sample));
      compare_field("mean_sample", 64'(exp_s.mean_sample), 64'(act_s.mean_sample));
      compare_field("earliest_time", exp_s.earliest_time, act_s.earliest_time);
      compare_field("latest_time", exp_s.latest_time, act_s.latest_time);
      compare_field("points_seen", 64'(exp_s.points_seen), 64'(act_s.points_seen));
    endfunction

    function int unsigned pending();
      return expected_stats.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;

  stats_tracker tracker = new();
  bit           quiet;
  int unsigned  sent;
  int unsigned  idle_cycles;

  running_min_max_mean_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offer one request and wait for it to be taken; valid stays high afterwards unless a random gap drops it
  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] ts);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {ts, s};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_sample(s, ts);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [SAMPLE_W-1:0] near_mean();
    longint v;
    v = longint'(tracker.mean) + longint'($urandom_range(0, 2000)) - 1000;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic random_sample();
    logic [SAMPLE_W-1:0] s;
    logic [TIME_W-1:0]   ts;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        s  = $urandom();
        ts = rand_time();
      end
      4, 5: begin
        s  = near_mean();
        ts = tracker.first_ts + {$urandom_range(0, 1000)};
      end
      6: begin
        // ties with the current extremes and window edges
        s  = $urandom_range(0, 1) ? tracker.lowest : tracker.highest;
        ts = $urandom_range(0, 1) ? tracker.first_ts : tracker.last_ts;
      end
      7: begin
        s  = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        ts = $urandom_range(0, 1) ? 64'd0 : {TIME_W{1'b1}};
      end
      default: begin
        s  = {{16{1'b0}}, 16'($urandom())} - 32'h0000_8000;
        ts = tracker.last_ts + {$urandom_range(1, 50)};
      end
    endcase
    send_sample(s, ts);
  endtask

  // stimulus
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    sent          = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first point sets everything, then extremes, ties and truncation
    send_sample(32'h0001_8000, 64'd1000);
    send_sample(32'h8000_0000, 64'd1000);
    send_sample(32'h7FFF_FFFF, 64'd0);
    send_sample(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(32'h8000_0000, 64'd500);
    send_sample(32'h7FFF_FFFF, 64'd500);
    send_sample(32'hFFFF_FFFF, 64'd2000);
    send_sample(32'h0000_0001, 64'd2000);
    send_sample(32'hFFFF_FFF9, 64'd3);
    send_sample(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_sample(32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
    send_sample(32'hFFFF_0000, 64'h8000_0000_0000_0000);
    send_sample(32'h0000_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_sample(32'h0000_0000, 64'd0);
    send_sample(32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(32'h8000_0000, 64'h0000_0000_FFFF_FFFF);

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      random_sample();
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d results, ties, extremes and out-of-order times",
             sent, tracker.checked);
    $display("final window %h..%h, samples %h..%h", tracker.first_ts, tracker.last_ts,
             tracker.lowest, tracker.highest);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: random stalls plus one long hold so the block backs up
  initial begin
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && tracker.checked >= HOLD_AFTER) begin
        held          = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_stats(m_axis_tdata);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles at %0t", idle_cycles, $time);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial idle_cycles = 0;

endmodule

@@ running_min_max_mean_top.f @@
src/rmm_pkg.sv
src/rmm_ctrl.sv
src/rmm_dp.sv
src/running_min_max_mean_top.sv
verif/tb_running_min_max_mean_top.sv
